>>> hw/rtl/mmc3bm_pkg.sv
// shared widths, codes, beat types and reset values of the bank mapper
package mmc3bm_pkg;

    // field widths
    localparam int FUNC_W    = 2;
    localparam int ADDR_W    = 16;
    localparam int VALUE_W   = 8;
    localparam int BANK_W    = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;

    // operation codes carried in func
    localparam logic [FUNC_W-1:0] FUNC_CPU_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK      = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PRG_QUERY = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CHR_QUERY = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANKS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_SCREEN = 1'd1;

    // configuration reset values
    localparam logic [CFG_DATA_W-1:0] PRG_BANKS_RESET = 9'd16;

    // fixed interrupt reload loaded by any irq register write
    localparam logic [7:0] IRQ_FIXED_RELOAD = 8'hBE;

    // one command beat
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ADDR_W-1:0]  address;
        logic [VALUE_W-1:0] value;
        logic               in_vblank;
    } cmd_t;

    // one response beat
    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic              irq_pulse;
        logic              mirror_horizontal;
    } rsp_t;

endpackage

>>> hw/rtl/mmc3bm_if.sv
// valid/ready channel interfaces for command and response beats
interface mmc3bm_cmd_if;
    import mmc3bm_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [ADDR_W-1:0]  address;
    logic [VALUE_W-1:0] value;
    logic               in_vblank;

    modport source (output valid, output func, output address, output value,
                    output in_vblank, input ready);
    modport sink   (input valid, input func, input address, input value,
                    input in_vblank, output ready);
endinterface

interface mmc3bm_rsp_if;
    import mmc3bm_pkg::*;

    logic              valid;
    logic              ready;
    logic [BANK_W-1:0] bank;
    logic              irq_pulse;
    logic              mirror_horizontal;

    modport source (output valid, output bank, output irq_pulse,
                    output mirror_horizontal, input ready);
    modport sink   (input valid, input bank, input irq_pulse,
                    input mirror_horizontal, output ready);
endinterface

>>> hw/rtl/mmc3_style_bank_mapper.sv
// top level of the bank mapper: input register, mapper logic, response register
//
//   channel | dir | beat contents                          | handshake
//   --------+-----+----------------------------------------+-------------------
//   cmd     | in  | func, address, value, in_vblank        | valid/ready
//   rsp     | out | bank, irq_pulse, mirror_horizontal     | valid/ready
//   cfg     | in  | cfg_index, cfg_wdata                   | cfg_we, no stall
//
// one beat per cycle sustained unless a low rsp.ready holds the flow; a response passes
// the command register, then the response register, one response per command.
// the command register keeps taking beats while a finished response waits;
// cmd.ready drops only when both registers are full and rsp.ready is low.
// rst_n sets the valid flags, mapper registers and configuration to their reset values at once.
module mmc3_style_bank_mapper (
    input  logic                                 clk,
    input  logic                                 rst_n,
    mmc3bm_cmd_if.sink                           cmd,
    mmc3bm_rsp_if.source                         rsp,
    input  logic                                 cfg_we,
    input  logic [mmc3bm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mmc3bm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import mmc3bm_pkg::*;

    cmd_t cmd_reg;
    logic cmd_valid_reg, cmd_valid_next;
    rsp_t rsp_reg;
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_item;
    logic advance;
    logic cmd_take;

    // pipeline flow control
    assign advance   = cmd_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign cmd.ready = !cmd_valid_reg || advance;
    assign cmd_take  = cmd.valid && cmd.ready;

    always_comb
    begin
        cmd_valid_next = cmd_take || (cmd_valid_reg && !advance);
        rsp_valid_next = advance || (rsp_valid_reg && !rsp.ready);
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // command and response payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_reg.func      <= cmd.func;
            cmd_reg.address   <= cmd.address;
            cmd_reg.value     <= cmd.value;
            cmd_reg.in_vblank <= cmd.in_vblank;
        end
        if (advance)
        begin
            rsp_reg <= rsp_item;
        end
    end

    // mapper state and translation
    mmc3bm_mapper u_mapper (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .cmd_item  (cmd_reg),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rsp_item  (rsp_item)
    );

    // response channel
    assign rsp.valid             = rsp_valid_reg;
    assign rsp.bank              = rsp_reg.bank;
    assign rsp.irq_pulse         = rsp_reg.irq_pulse;
    assign rsp.mirror_horizontal = rsp_reg.mirror_horizontal;

endmodule

>>> hw/rtl/mmc3bm_mapper.sv
// mapper registers, cpu write decode, irq counter and bank translation
module mmc3bm_mapper (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 step_en,
    input  mmc3bm_pkg::cmd_t                     cmd_item,
    input  logic                                 cfg_we,
    input  logic [mmc3bm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mmc3bm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output mmc3bm_pkg::rsp_t                     rsp_item
);
    import mmc3bm_pkg::*;

    // cpu write decode of address bits 14, 13 and 0
    localparam logic [2:0] DEC_MODE    = 3'b000;
    localparam logic [2:0] DEC_BANK    = 3'b001;
    localparam logic [2:0] DEC_MIRROR  = 3'b010;
    localparam logic [2:0] DEC_IRQ_OFF = 3'b100;
    localparam logic [2:0] DEC_IRQ_ON  = 3'b101;

    // bank register index codes
    localparam logic [2:0] IDX_CHR_LOW  = 3'd0;
    localparam logic [2:0] IDX_CHR_HIGH = 3'd1;
    localparam logic [2:0] IDX_CHR_S0   = 3'd2;
    localparam logic [2:0] IDX_CHR_S1   = 3'd3;
    localparam logic [2:0] IDX_CHR_S2   = 3'd4;
    localparam logic [2:0] IDX_CHR_S3   = 3'd5;
    localparam logic [2:0] IDX_PRG_0    = 3'd6;

    logic [CFG_DATA_W-1:0] prg_banks_reg;
    logic                  four_screen_reg;

    logic [2:0] mode_index_reg,   mode_index_next;
    logic       prg_mode_reg,     prg_mode_next;
    logic       chr_swap_reg,     chr_swap_next;
    logic [7:0] chr_pair_low_reg, chr_pair_low_next;
    logic [7:0] chr_pair_high_reg, chr_pair_high_next;
    logic [7:0] chr_single_reg [4];
    logic [7:0] chr_single_next [4];
    logic [7:0] prg_first_reg,    prg_first_next;
    logic [7:0] prg_second_reg,   prg_second_next;
    logic       override_active_reg, override_active_next;
    logic [7:0] override_bank_reg, override_bank_next;
    logic       mirroring_reg,    mirroring_next;
    logic       irq_enabled_reg,  irq_enabled_next;
    logic [7:0] irq_count_reg,    irq_count_next;
    logic [7:0] irq_reload_reg,   irq_reload_next;

    logic              is_override_range;
    logic [2:0]        write_decode;
    logic              tick_pulse;
    logic [BANK_W-1:0] last_bank;
    logic [BANK_W-1:0] last_bank_m1;
    logic [1:0]        prg_window;
    logic [BANK_W-1:0] prg_bank;
    logic [2:0]        chr_slot;
    logic [BANK_W-1:0] chr_bank;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_banks_reg   <= PRG_BANKS_RESET;
            four_screen_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PRG_BANKS:   prg_banks_reg   <= cfg_wdata;
                CFG_FOUR_SCREEN: four_screen_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // address range and register decode of a cpu write
    assign is_override_range =
        ((cmd_item.address[15:12] == 4'h4) && (cmd_item.address[11:8] != 4'h0)) ||
        (cmd_item.address[15:13] == 3'b011);
    assign write_decode = {cmd_item.address[14:13], cmd_item.address[0]};

    // next state for writes and scanline ticks
    always_comb
    begin
        mode_index_next      = mode_index_reg;
        prg_mode_next        = prg_mode_reg;
        chr_swap_next        = chr_swap_reg;
        chr_pair_low_next    = chr_pair_low_reg;
        chr_pair_high_next   = chr_pair_high_reg;
        chr_single_next      = chr_single_reg;
        prg_first_next       = prg_first_reg;
        prg_second_next      = prg_second_reg;
        override_active_next = override_active_reg;
        override_bank_next   = override_bank_reg;
        mirroring_next       = mirroring_reg;
        irq_enabled_next     = irq_enabled_reg;
        irq_count_next       = irq_count_reg;
        irq_reload_next      = irq_reload_reg;
        tick_pulse           = 1'b0;

        if (cmd_item.func == FUNC_CPU_WRITE)
        begin
            if (is_override_range)
            begin
                override_active_next = 1'b1;
                override_bank_next   = cmd_item.value;
            end
            else if (cmd_item.address[15])
            begin
                case (write_decode)
                    DEC_MODE:
                    begin
                        mode_index_next      = cmd_item.value[2:0];
                        prg_mode_next        = cmd_item.value[6];
                        chr_swap_next        = cmd_item.value[7];
                        override_active_next = 1'b0;
                    end
                    DEC_BANK:
                    begin
                        case (mode_index_reg)
                            IDX_CHR_LOW:  chr_pair_low_next  = {cmd_item.value[7:1], 1'b0};
                            IDX_CHR_HIGH: chr_pair_high_next = {cmd_item.value[7:1], 1'b0};
                            IDX_CHR_S0:   chr_single_next[0] = cmd_item.value;
                            IDX_CHR_S1:   chr_single_next[1] = cmd_item.value;
                            IDX_CHR_S2:   chr_single_next[2] = cmd_item.value;
                            IDX_CHR_S3:   chr_single_next[3] = cmd_item.value;
                            IDX_PRG_0:
                            begin
                                prg_first_next       = cmd_item.value;
                                override_active_next = 1'b0;
                            end
                            default:
                            begin
                                prg_second_next      = cmd_item.value;
                                override_active_next = 1'b0;
                            end
                        endcase
                    end
                    DEC_MIRROR:
                    begin
                        if (!four_screen_reg)
                        begin
                            mirroring_next = cmd_item.value[0];
                        end
                    end
                    DEC_IRQ_OFF, DEC_IRQ_ON:
                    begin
                        irq_enabled_next = cmd_item.address[0];
                        irq_reload_next  = IRQ_FIXED_RELOAD;
                        irq_count_next   = IRQ_FIXED_RELOAD;
                    end
                    default: ;
                endcase
            end
        end
        else if (cmd_item.func == FUNC_TICK)
        begin
            // post-decrement counter, reload and pulse when already zero
            if (!cmd_item.in_vblank && irq_enabled_reg)
            begin
                if (irq_count_reg == 8'd0)
                begin
                    irq_count_next = irq_reload_reg;
                    tick_pulse     = 1'b1;
                end
                else
                begin
                    irq_count_next = irq_count_reg - 8'd1;
                end
            end
        end
    end

    // mapper state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_index_reg      <= 3'd0;
            prg_mode_reg        <= 1'b0;
            chr_swap_reg        <= 1'b0;
            chr_pair_low_reg    <= 8'd0;
            chr_pair_high_reg   <= 8'd2;
            chr_single_reg[0]   <= 8'd4;
            chr_single_reg[1]   <= 8'd5;
            chr_single_reg[2]   <= 8'd6;
            chr_single_reg[3]   <= 8'd7;
            prg_first_reg       <= 8'd0;
            prg_second_reg      <= 8'd1;
            override_active_reg <= 1'b0;
            override_bank_reg   <= 8'd0;
            mirroring_reg       <= 1'b0;
            irq_enabled_reg     <= 1'b0;
            irq_count_reg       <= 8'd0;
            irq_reload_reg      <= 8'd0;
        end
        else if (step_en)
        begin
            mode_index_reg      <= mode_index_next;
            prg_mode_reg        <= prg_mode_next;
            chr_swap_reg        <= chr_swap_next;
            chr_pair_low_reg    <= chr_pair_low_next;
            chr_pair_high_reg   <= chr_pair_high_next;
            chr_single_reg      <= chr_single_next;
            prg_first_reg       <= prg_first_next;
            prg_second_reg      <= prg_second_next;
            override_active_reg <= override_active_next;
            override_bank_reg   <= override_bank_next;
            mirroring_reg       <= mirroring_next;
            irq_enabled_reg     <= irq_enabled_next;
            irq_count_reg       <= irq_count_next;
            irq_reload_reg      <= irq_reload_next;
        end
    end

    // last and second to last 8 KB banks, modulo 512
    assign last_bank    = {prg_banks_reg[7:0], 1'b0} - 9'd1;
    assign last_bank_m1 = last_bank - 9'd1;

    // program window translation
    assign prg_window = cmd_item.address[14:13];
    always_comb
    begin
        if (!cmd_item.address[15])
        begin
            prg_bank = '0;
        end
        else if (prg_window == 2'd3)
        begin
            prg_bank = last_bank;
        end
        else if (override_active_reg)
        begin
            case (prg_window)
                2'd0:    prg_bank = {override_bank_reg, 1'b0};
                2'd1:    prg_bank = {override_bank_reg, 1'b1};
                default: prg_bank = last_bank_m1;
            endcase
        end
        else if (prg_window == 2'd1)
        begin
            prg_bank = {1'b0, prg_second_reg};
        end
        else if ((prg_window == 2'd0) != prg_mode_reg)
        begin
            prg_bank = {1'b0, prg_first_reg};
        end
        else
        begin
            prg_bank = last_bank_m1;
        end
    end

    // pattern slot translation with optional half swap
    assign chr_slot = cmd_item.address[12:10] ^ {chr_swap_reg, 2'b00};
    always_comb
    begin
        case (chr_slot)
            3'd0:    chr_bank = {1'b0, chr_pair_low_reg};
            3'd1:    chr_bank = {1'b0, chr_pair_low_reg} + 9'd1;
            3'd2:    chr_bank = {1'b0, chr_pair_high_reg};
            3'd3:    chr_bank = {1'b0, chr_pair_high_reg} + 9'd1;
            default: chr_bank = {1'b0, chr_single_reg[chr_slot[1:0]]};
        endcase
    end

    // response fields, mirroring as it stands after this beat
    always_comb
    begin
        case (cmd_item.func)
            FUNC_PRG_QUERY: rsp_item.bank = prg_bank;
            FUNC_CHR_QUERY: rsp_item.bank = chr_bank;
            default:        rsp_item.bank = '0;
        endcase
        rsp_item.irq_pulse         = tick_pulse;
        rsp_item.mirror_horizontal = mirroring_next;
    end

endmodule

>>> hw/rtl/mmc3bm_checker.sv
// port-level checks of the bank mapper and their bind to the top level
module mmc3bm_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_ready,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  logic [mmc3bm_pkg::BANK_W-1:0] rsp_bank,
    input  logic                          rsp_irq_pulse,
    input  logic                          rsp_mirror_horizontal
);
    import mmc3bm_pkg::*;

    // a stalled response beat holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bank) &&
            $stable(rsp_irq_pulse) && $stable(rsp_mirror_horizontal))
        else $error("response beat changed while stalled");

    // command side only stalls behind a full, stalled response register
    a_cmd_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> rsp_valid && !rsp_ready)
        else $error("command stalled without response backpressure");

    // an interrupt beat is a tick, never a query with a bank
    a_irq_no_bank: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_irq_pulse |-> rsp_bank == '0)
        else $error("irq pulse carried a nonzero bank");

    // the counter reloads to a large value, so two pulses never come in a row
    a_irq_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && rsp_irq_pulse |=> !(rsp_valid && rsp_irq_pulse))
        else $error("irq pulses on consecutive responses");

endmodule

bind mmc3_style_bank_mapper mmc3bm_checker u_mmc3bm_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd_ready             (cmd.ready),
    .rsp_valid             (rsp.valid),
    .rsp_ready             (rsp.ready),
    .rsp_bank              (rsp.bank),
    .rsp_irq_pulse         (rsp.irq_pulse),
    .rsp_mirror_horizontal (rsp.mirror_horizontal)
);
